// ===== rtl/core/rwrb_pkg.sv =====
// shared types and constants of the receive window reorder buffer
package rwrb_pkg;

   localparam int SEQ_W = 16;
   localparam int TAG_W = 16;
   localparam int WIN_W = 5;
   localparam int FREE_W = 5;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 3;

   localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;
   localparam logic [SEQ_W-1:0] ACK_RESET = 16'd2;

   // request command codes
   localparam logic CMD_SEGMENT = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_ARRIVE,
      OP_DRAIN
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STATUS  = 2'd0,
      KIND_DRAINED = 2'd1,
      KIND_EMPTY   = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED        = 3'd0,
      ST_DUPLICATE     = 3'd1,
      ST_NOT_EXPECTED  = 3'd2,
      ST_FULL          = 3'd3,
      ST_OUT_OF_WINDOW = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ARR_EVAL,
      BK_WALK,
      BK_ACK_READ,
      BK_ACK_SET,
      BK_DRN_START,
      BK_DRN_EMIT
   } back_state_type;

   typedef struct packed {
      op_type            op;
      logic [SEQ_W-1:0]  seq;
      logic [TAG_W-1:0]  tag;
   } item_type;

   typedef struct packed {
      kind_type           kind;
      status_type         status;
      logic [SEQ_W-1:0]   seq;
      logic [TAG_W-1:0]   tag;
      logic [SEQ_W-1:0]   ack;
      logic [FREE_W-1:0]  free;
      logic               last;
   } rsp_type;

endpackage

// ===== rtl/core/rwrb_queue.sv =====
// short request queue between the front and the back
module rwrb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rwrb_pkg::item_type push_item,
   input  logic               pop,
   output rwrb_pkg::item_type pop_item,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = (rwrb_pkg::QUEUE_DEPTH > 1) ? $clog2(rwrb_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(rwrb_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rwrb_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rwrb_pkg::QUEUE_DEPTH);

   rwrb_pkg::item_type entry_ff [rwrb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty = (count_ff == '0);
   assign full = (count_ff == CNT_FULL);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/rwrb_front.sv =====
// request intake: registers a request, decodes its command and hands it to the queue
module rwrb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        req_cmd,
   input  logic [rwrb_pkg::SEQ_W-1:0]  req_seq,
   input  logic [rwrb_pkg::TAG_W-1:0]  req_payload_tag,
   input  logic                        q_full,
   output logic                        push,
   output rwrb_pkg::item_type          push_item,
   output logic                        pending
);

   logic               valid_ff, valid_in;
   rwrb_pkg::item_type item_ff, item_in;
   rwrb_pkg::op_type   op_dec;

   always_comb begin
      case (req_cmd)
         rwrb_pkg::CMD_SEGMENT: op_dec = rwrb_pkg::OP_ARRIVE;
         rwrb_pkg::CMD_DRAIN:   op_dec = rwrb_pkg::OP_DRAIN;
         default:               op_dec = rwrb_pkg::OP_ARRIVE;
      endcase
   end

   assign push = valid_ff && !q_full;
   assign push_item = item_ff;
   assign pending = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in.op = op_dec;
         item_in.seq = req_seq;
         item_in.tag = req_payload_tag;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ===== rtl/core/rwrb_back.sv =====
// slot ring, in-order walk and drain sequencer of the reorder buffer
module rwrb_back #(
   parameter int MAX_SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [rwrb_pkg::WIN_W-1:0]  csr_data,
   input  logic                        q_empty,
   input  rwrb_pkg::item_type          q_item,
   output logic                        q_pop,
   output logic                        active,
   output logic                        rsp_valid,
   output rwrb_pkg::rsp_type           rsp
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int SEQ_W = rwrb_pkg::SEQ_W;
   localparam int TAG_W = rwrb_pkg::TAG_W;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p,
                                                 input logic [CNT_W-1:0] w);
      logic [CNT_W-1:0] s;
      s = CNT_W'(p) + CNT_W'(1);
      wrap_inc = (s == w) ? '0 : IDX_W'(s);
   endfunction

   rwrb_pkg::back_state_type state_ff, state_in;

   logic [MAX_SLOTS-1:0]        occ_ff, occ_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [IDX_W-1:0]            head_ff, head_in;
   logic [IDX_W-1:0]            end_ff, end_in;
   logic [SEQ_W-1:0]            ack_ff, ack_in;
   logic [rwrb_pkg::WIN_W-1:0]  win_raw_ff, win_raw_in;
   rwrb_pkg::item_type          item_ff, item_in;
   logic [IDX_W-1:0]            walk_p_ff, walk_p_in;
   logic [CNT_W-1:0]            walk_steps_ff, walk_steps_in;
   logic [IDX_W-1:0]            drn_p_ff, drn_p_in;
   logic [CNT_W-1:0]            drn_left_ff, drn_left_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rwrb_pkg::rsp_type           rsp_ff, rsp_in;

   // slot contents
   logic [SEQ_W-1:0]  slot_seq_ff [MAX_SLOTS];
   logic [TAG_W-1:0]  slot_tag_ff [MAX_SLOTS];
   logic [SEQ_W-1:0]  rd_seq_ff;
   logic [TAG_W-1:0]  rd_tag_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [SEQ_W-1:0]  wr_seq;
   logic [TAG_W-1:0]  wr_tag;

   // decode
   logic [CNT_W-1:0]    win;
   logic                ring_full;
   logic                head_occ;
   logic [SEQ_W:0]      diff;
   logic                diff_neg;
   logic                diff_big;
   logic [CNT_W:0]      tsum;
   logic [IDX_W-1:0]    target;
   logic                arr_store;
   logic [IDX_W-1:0]    arr_addr;
   rwrb_pkg::status_type arr_status;
   logic [CNT_W-1:0]    ring_span;
   logic [IDX_W-1:0]    walk_q;
   logic [IDX_W-1:0]    drn_q;
   logic                walk_more;
   logic                drn_last;

   always_comb begin
      if (win_raw_ff == '0) begin
         win = CNT_W'(1);
      end else if (int'(win_raw_ff) > MAX_SLOTS) begin
         win = CNT_W'(MAX_SLOTS);
      end else begin
         win = CNT_W'(win_raw_ff);
      end
   end

   assign ring_full = (cnt_ff == win);
   assign head_occ = occ_ff[head_ff];
   assign diff = {1'b0, item_ff.seq} - {1'b0, rd_seq_ff};
   assign diff_neg = diff[SEQ_W];
   assign diff_big = (diff[SEQ_W-1:0] >= SEQ_W'(win));
   assign tsum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(diff[CNT_W-1:0]);
   assign target = (tsum >= (CNT_W+1)'(win)) ? IDX_W'(tsum - (CNT_W+1)'(win))
                                            : IDX_W'(tsum);
   assign walk_q = wrap_inc(walk_p_ff, win);
   assign drn_q = wrap_inc(drn_p_ff, win);
   assign walk_more = (walk_steps_ff < win) && occ_ff[walk_q];
   assign drn_last = (drn_left_ff == CNT_W'(1));

   // ring distance from head to in-order end
   assign ring_span = (end_ff >= head_ff) ? CNT_W'(end_ff) - CNT_W'(head_ff)
                                          : (win - CNT_W'(head_ff)) + CNT_W'(end_ff);

   // arrival classification against the head slot
   always_comb begin
      arr_store = 1'b0;
      arr_addr = head_ff;
      arr_status = rwrb_pkg::ST_STORED;
      if (ring_full) begin
         arr_status = rwrb_pkg::ST_FULL;
      end else if (!head_occ) begin
         if (item_ff.seq == ack_ff) begin
            arr_store = 1'b1;
         end else begin
            arr_status = rwrb_pkg::ST_NOT_EXPECTED;
         end
      end else if (diff_neg) begin
         arr_status = rwrb_pkg::ST_DUPLICATE;
      end else if (diff_big) begin
         arr_status = rwrb_pkg::ST_OUT_OF_WINDOW;
      end else if (occ_ff[target]) begin
         arr_status = rwrb_pkg::ST_DUPLICATE;
      end else begin
         arr_store = 1'b1;
         arr_addr = target;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rwrb_pkg::BK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_item.op == rwrb_pkg::OP_DRAIN) ? rwrb_pkg::BK_DRN_START
                                                            : rwrb_pkg::BK_ARR_EVAL;
            end
         end
         rwrb_pkg::BK_ARR_EVAL: begin
            state_in = arr_store ? rwrb_pkg::BK_WALK : rwrb_pkg::BK_IDLE;
         end
         rwrb_pkg::BK_WALK: begin
            if (!occ_ff[walk_p_ff]) begin
               state_in = rwrb_pkg::BK_IDLE;
            end else if (!walk_more) begin
               state_in = rwrb_pkg::BK_ACK_READ;
            end
         end
         rwrb_pkg::BK_ACK_READ: state_in = rwrb_pkg::BK_ACK_SET;
         rwrb_pkg::BK_ACK_SET:  state_in = rwrb_pkg::BK_IDLE;
         rwrb_pkg::BK_DRN_START: begin
            state_in = head_occ ? rwrb_pkg::BK_DRN_EMIT : rwrb_pkg::BK_IDLE;
         end
         rwrb_pkg::BK_DRN_EMIT: begin
            if (drn_last) begin
               state_in = rwrb_pkg::BK_IDLE;
            end
         end
         default: state_in = rwrb_pkg::BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      occ_in = occ_ff;
      cnt_in = cnt_ff;
      head_in = head_ff;
      end_in = end_ff;
      ack_in = ack_ff;
      win_raw_in = win_raw_ff;
      item_in = item_ff;
      walk_p_in = walk_p_ff;
      walk_steps_in = walk_steps_ff;
      drn_p_in = drn_p_ff;
      drn_left_in = drn_left_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      rd_addr = head_ff;
      wr_en = 1'b0;
      wr_addr = arr_addr;
      wr_seq = item_ff.seq;
      wr_tag = item_ff.tag;

      case (state_ff)
         rwrb_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               item_in = q_item;
            end
         end
         rwrb_pkg::BK_ARR_EVAL: begin
            if (arr_store) begin
               wr_en = 1'b1;
               occ_in[arr_addr] = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
               walk_p_in = end_ff;
               walk_steps_in = CNT_W'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in.kind = rwrb_pkg::KIND_STATUS;
               rsp_in.status = arr_status;
               rsp_in.seq = '0;
               rsp_in.tag = '0;
               rsp_in.last = 1'b1;
            end
         end
         rwrb_pkg::BK_WALK: begin
            if (!occ_ff[walk_p_ff]) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind = rwrb_pkg::KIND_STATUS;
               rsp_in.status = rwrb_pkg::ST_STORED;
               rsp_in.seq = '0;
               rsp_in.tag = '0;
               rsp_in.last = 1'b1;
            end else if (walk_more) begin
               walk_p_in = walk_q;
               walk_steps_in = walk_steps_ff + CNT_W'(1);
            end else begin
               end_in = walk_p_ff;
            end
         end
         rwrb_pkg::BK_ACK_READ: begin
            rd_addr = end_ff;
         end
         rwrb_pkg::BK_ACK_SET: begin
            ack_in = rd_seq_ff + SEQ_W'(1);
            rsp_valid_in = 1'b1;
            rsp_in.kind = rwrb_pkg::KIND_STATUS;
            rsp_in.status = rwrb_pkg::ST_STORED;
            rsp_in.seq = '0;
            rsp_in.tag = '0;
            rsp_in.last = 1'b1;
         end
         rwrb_pkg::BK_DRN_START: begin
            if (!head_occ) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind = rwrb_pkg::KIND_EMPTY;
               rsp_in.status = rwrb_pkg::ST_STORED;
               rsp_in.seq = '0;
               rsp_in.tag = '0;
               rsp_in.last = 1'b1;
            end else begin
               drn_p_in = head_ff;
               drn_left_in = ring_span + CNT_W'(1);
               rd_addr = head_ff;
            end
         end
         rwrb_pkg::BK_DRN_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind = rwrb_pkg::KIND_DRAINED;
            rsp_in.status = rwrb_pkg::ST_STORED;
            rsp_in.seq = rd_seq_ff;
            rsp_in.tag = rd_tag_ff;
            rsp_in.last = drn_last;
            occ_in[drn_p_ff] = 1'b0;
            cnt_in = cnt_ff - CNT_W'(1);
            rd_addr = drn_q;
            drn_p_in = drn_q;
            drn_left_in = drn_left_ff - CNT_W'(1);
            if (drn_last) begin
               head_in = drn_q;
               end_in = drn_q;
            end
         end
         default: begin
         end
      endcase

      // window write frees the whole ring
      if (csr_we) begin
         win_raw_in = csr_data;
         occ_in = '0;
         cnt_in = '0;
         head_in = '0;
         end_in = '0;
      end

      if (rsp_valid_in) begin
         rsp_in.ack = ack_in;
         rsp_in.free = rwrb_pkg::FREE_W'(win - cnt_in);
      end
   end

   assign active = (state_ff != rwrb_pkg::BK_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rwrb_pkg::BK_IDLE;
         occ_ff <= '0;
         cnt_ff <= '0;
         head_ff <= '0;
         end_ff <= '0;
         ack_ff <= rwrb_pkg::ACK_RESET;
         win_raw_ff <= rwrb_pkg::WIN_RESET;
         walk_steps_ff <= '0;
         drn_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         cnt_ff <= cnt_in;
         head_ff <= head_in;
         end_ff <= end_in;
         ack_ff <= ack_in;
         win_raw_ff <= win_raw_in;
         walk_steps_ff <= walk_steps_in;
         drn_left_ff <= drn_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      walk_p_ff <= walk_p_in;
      drn_p_ff <= drn_p_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_seq_ff[wr_addr] <= wr_seq;
         slot_tag_ff[wr_addr] <= wr_tag;
      end
      rd_seq_ff <= slot_seq_ff[rd_addr];
      rd_tag_ff <= slot_tag_ff[rd_addr];
   end

endmodule

// ===== rtl/core/receive_window_reorder_buffer.sv =====
// top level of the receive window reorder buffer
//
// usage
//  - a request is taken on a rising edge with start high and busy low; req_cmd
//    selects a segment arrival or a drain of the in-order run at the head
//  - results come out on the rsp_ ports for exactly one cycle each, marked by
//    rsp_strobe; rsp_last flags the final result of a request
//  - the receiver cannot stall, results are simply presented and taken
//  - one request at a time: busy stays high from acceptance until the last
//    result is on the ports, so a new request may be taken in that cycle
//  - a refused or ignored arrival shows its status once it has passed the front
//    register, the queue and ARR_EVAL; a stored arrival goes on through WALK,
//    ACK_READ and ACK_SET, the walk covering 0 to window_size - 1 ring steps
//  - drain: the first result passes DRN_START, the registered slot read and
//    DRN_EMIT, then one drained segment every cycle; an empty head gives a
//    single result from DRN_START; the walk is one slot per cycle and slot
//    contents come from a single registered read port
//  - window register: csr_valid/csr_ready, taken only while idle; writing it
//    frees every slot and rewinds head and in-order end, ack is kept
//  - reset (synchronous): window 16, all slots free, ack 2; no clearing pass
module receive_window_reorder_buffer #(
   parameter int MAX_SLOTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [rwrb_pkg::SEQ_W-1:0]     req_seq,
   input  logic [rwrb_pkg::TAG_W-1:0]     req_payload_tag,
   // result channel
   output logic                           rsp_strobe,
   output logic [rwrb_pkg::KIND_W-1:0]    rsp_kind,
   output logic [rwrb_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rwrb_pkg::SEQ_W-1:0]     rsp_out_seq,
   output logic [rwrb_pkg::TAG_W-1:0]     rsp_out_payload_tag,
   output logic [rwrb_pkg::SEQ_W-1:0]     rsp_ack_number,
   output logic [rwrb_pkg::FREE_W-1:0]    rsp_free_slots,
   output logic                           rsp_last,
   // window size register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rwrb_pkg::WIN_W-1:0]     csr_window_size
);

   logic               req_accept;
   logic               front_push;
   logic               front_pending;
   rwrb_pkg::item_type front_item;
   logic               q_pop;
   logic               q_empty;
   logic               q_full;
   rwrb_pkg::item_type q_item;
   logic               back_active;
   logic               back_rsp_valid;
   rwrb_pkg::rsp_type  back_rsp;
   logic               csr_we;

   // busy while a request sits anywhere between intake and result register
   assign busy = front_pending || !q_empty || back_active;
   assign req_accept = start && !busy;

   // window changes only with nothing in flight
   assign csr_ready = !busy;
   assign csr_we = csr_valid && csr_ready;

   // front: registers and decodes the request
   rwrb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .req_cmd         (req_cmd),
      .req_seq         (req_seq),
      .req_payload_tag (req_payload_tag),
      .q_full          (q_full),
      .push            (front_push),
      .push_item       (front_item),
      .pending         (front_pending)
   );

   // decoupling queue
   rwrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: slot ring, walk and drain
   rwrb_back #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_data  (csr_window_size),
      .q_empty   (q_empty),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .active    (back_active),
      .rsp_valid (back_rsp_valid),
      .rsp       (back_rsp)
   );

   // result ports straight from the output register
   assign rsp_strobe = back_rsp_valid;
   assign rsp_kind = back_rsp.kind;
   assign rsp_status = back_rsp.status;
   assign rsp_out_seq = back_rsp.seq;
   assign rsp_out_payload_tag = back_rsp.tag;
   assign rsp_ack_number = back_rsp.ack;
   assign rsp_free_slots = back_rsp.free;
   assign rsp_last = back_rsp.last;

   // a result that is not the last one leaves the block still busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
   else $error("non-final result while block idle");

   // arrival status and empty drain always close their request
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind != rwrb_pkg::KIND_DRAINED |-> rsp_last)
   else $error("single-result kind without last");

   // an accepted request holds busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy)
   else $error("request accepted but block not busy");

endmodule
